### src/assert_macros.svh
// Assertion macros used by the checker file of the lexer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NLEX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NLEX_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/nlex_pkg.sv
// Shared types, codes and constants of the number literal lexer.
package nlex_pkg;

	// Default saturation limit of the lexeme length.
	localparam int unsigned MAX_LEN_DEFAULT = 255;

	// Queue between front end and back end; depth must be a power of two.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	// Stream widths.
	localparam int unsigned S_TDATA_W = 8;
	localparam int unsigned M_TDATA_W = 16;

	// Item kinds carried on s_tuser.
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_EOS  = 1'b1;

	// Character classes produced by the front end.
	typedef enum logic [3:0] {
		CC_OTHER,
		CC_DIGIT,
		CC_MINUS,
		CC_DOT,
		CC_NUMEND,
		CC_SEMI,
		CC_T,
		CC_R,
		CC_U,
		CC_E,
		CC_F,
		CC_A,
		CC_L,
		CC_S,
		CC_EOS
	} char_class_t;

	// One classified word handed to the queue.
	typedef struct packed {
		logic        valid;
		char_class_t cls;
	} qword_t;

	// Automaton states.
	typedef enum logic [3:0] {
		ST_START,
		ST_SIGN,
		ST_INT,
		ST_DOT,
		ST_FRAC,
		ST_T1,
		ST_T2,
		ST_T3,
		ST_TRUE,
		ST_F1,
		ST_F2,
		ST_F3,
		ST_F4,
		ST_FALSE
	} lex_state_t;

	// Token class codes.
	typedef logic [2:0] token_class_t;
	localparam token_class_t TC_POS_INT = 3'd0;
	localparam token_class_t TC_NEG_INT = 3'd1;
	localparam token_class_t TC_POS_DEC = 3'd2;
	localparam token_class_t TC_NEG_DEC = 3'd3;
	localparam token_class_t TC_TRUE    = 3'd4;
	localparam token_class_t TC_FALSE   = 3'd5;

	// Characters that close a number (minus and semicolon included).
	function automatic logic ends_number(char_class_t c);
		return (c == CC_NUMEND) || (c == CC_SEMI) || (c == CC_MINUS);
	endfunction

endpackage

### src/nlex_front.sv
// Front end: accepts input words and classifies each character.
module nlex_front (
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [nlex_pkg::S_TDATA_W-1:0]      s_tdata,
	input  logic                                s_tuser,
	input  logic                                q_full,
	output nlex_pkg::qword_t                    q_wr
);

	nlex_pkg::char_class_t cls;

	// Character decoder; the end-of-string kind overrides the byte.
	always_comb begin
		if (s_tuser == nlex_pkg::KIND_EOS) begin
			cls = nlex_pkg::CC_EOS;
		end else begin
			unique case (s_tdata) inside
				["0":"9"]:                    cls = nlex_pkg::CC_DIGIT;
				"-":                          cls = nlex_pkg::CC_MINUS;
				".":                          cls = nlex_pkg::CC_DOT;
				";":                          cls = nlex_pkg::CC_SEMI;
				"+", "*", "/", "%", ",", ")": cls = nlex_pkg::CC_NUMEND;
				"t":                          cls = nlex_pkg::CC_T;
				"r":                          cls = nlex_pkg::CC_R;
				"u":                          cls = nlex_pkg::CC_U;
				"e":                          cls = nlex_pkg::CC_E;
				"f":                          cls = nlex_pkg::CC_F;
				"a":                          cls = nlex_pkg::CC_A;
				"l":                          cls = nlex_pkg::CC_L;
				"s":                          cls = nlex_pkg::CC_S;
				default:                      cls = nlex_pkg::CC_OTHER;
			endcase
		end
	end

	// A word is taken whenever the queue has room.
	assign s_tready    = !q_full;
	assign q_wr.valid  = s_tvalid && !q_full;
	assign q_wr.cls    = cls;

endmodule

### src/nlex_queue.sv
// Short queue of classified words between front end and back end.
module nlex_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nlex_pkg::qword_t      wr,
	output logic                  full,
	output nlex_pkg::qword_t      rd,
	input  logic                  pop
);

	localparam int unsigned PW = nlex_pkg::QPTR_W;

	nlex_pkg::char_class_t  slot_q [nlex_pkg::QUEUE_DEPTH];
	logic [PW-1:0]          wr_ptr_q;
	logic [PW-1:0]          rd_ptr_q;
	logic [PW:0]            fill_q;
	logic                   do_pop;

	assign full   = (fill_q == (PW+1)'(nlex_pkg::QUEUE_DEPTH));
	assign rd.valid = (fill_q != '0);
	assign rd.cls   = slot_q[rd_ptr_q];
	assign do_pop = pop && rd.valid;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr.valid) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (wr.valid && !do_pop) begin
				fill_q <= fill_q + (PW+1)'(1);
			end else if (!wr.valid && do_pop) begin
				fill_q <= fill_q - (PW+1)'(1);
			end
		end
	end

	// Slot storage.
	always_ff @(posedge clk) begin
		if (wr.valid) begin
			slot_q[wr_ptr_q] <= wr.cls;
		end
	end

endmodule

### src/nlex_back.sv
// Back end: runs the lexer automaton and holds the result word.
module nlex_back #(
	parameter int unsigned MAX_LEN = nlex_pkg::MAX_LEN_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  nlex_pkg::qword_t                  rd,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [nlex_pkg::M_TDATA_W-1:0]    m_tdata
);

	localparam int unsigned CNT_RAW = $clog2(MAX_LEN + 1);
	localparam int unsigned CNT_W   = (CNT_RAW > 8) ? CNT_RAW : 8;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

	nlex_pkg::lex_state_t   state_q;
	nlex_pkg::lex_state_t   state_d;
	logic                   neg_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   decided_q;
	logic                   sat_q;
	logic                   m_tvalid_q;
	logic [nlex_pkg::M_TDATA_W-1:0] m_tdata_q;

	logic                   count_en;
	logic                   set_neg;
	logic                   emit;
	logic                   ok;
	nlex_pkg::token_class_t tc;
	logic                   is_eos;
	logic [nlex_pkg::M_TDATA_W-1:0] result_d;

	// One word per cycle while the result register is free or being drained.
	assign pop    = rd.valid && (!m_tvalid_q || m_tready);
	assign is_eos = (rd.cls == nlex_pkg::CC_EOS);

	// Next state of the automaton and the decision of this word.
	always_comb begin
		state_d  = state_q;
		count_en = 1'b0;
		set_neg  = 1'b0;
		emit     = 1'b0;
		ok       = 1'b0;
		tc       = nlex_pkg::TC_POS_INT;
		if (is_eos) begin
			emit = !decided_q;
			unique case (state_q)
				nlex_pkg::ST_INT: begin
					ok = 1'b1;
					tc = neg_q ? nlex_pkg::TC_NEG_INT : nlex_pkg::TC_POS_INT;
				end
				nlex_pkg::ST_FRAC: begin
					ok = 1'b1;
					tc = neg_q ? nlex_pkg::TC_NEG_DEC : nlex_pkg::TC_POS_DEC;
				end
				nlex_pkg::ST_TRUE: begin
					ok = 1'b1;
					tc = nlex_pkg::TC_TRUE;
				end
				nlex_pkg::ST_FALSE: begin
					ok = 1'b1;
					tc = nlex_pkg::TC_FALSE;
				end
				default: begin
					ok = 1'b0;
				end
			endcase
		end else if (!decided_q) begin
			unique case (state_q)
				nlex_pkg::ST_START: begin
					count_en = 1'b1;
					if (rd.cls == nlex_pkg::CC_MINUS) begin
						set_neg = 1'b1;
						state_d = nlex_pkg::ST_SIGN;
					end else if (rd.cls == nlex_pkg::CC_DIGIT) begin
						state_d = nlex_pkg::ST_INT;
					end else if (rd.cls == nlex_pkg::CC_T) begin
						state_d = nlex_pkg::ST_T1;
					end else if (rd.cls == nlex_pkg::CC_F) begin
						state_d = nlex_pkg::ST_F1;
					end else begin
						count_en = 1'b0;
						emit     = 1'b1;
					end
				end
				nlex_pkg::ST_SIGN, nlex_pkg::ST_DOT: begin
					if (rd.cls == nlex_pkg::CC_DIGIT) begin
						count_en = 1'b1;
						state_d  = (state_q == nlex_pkg::ST_SIGN) ?
							nlex_pkg::ST_INT : nlex_pkg::ST_FRAC;
					end else begin
						emit = 1'b1;
					end
				end
				nlex_pkg::ST_INT: begin
					if (rd.cls == nlex_pkg::CC_DIGIT) begin
						count_en = 1'b1;
					end else if (rd.cls == nlex_pkg::CC_DOT) begin
						count_en = 1'b1;
						state_d  = nlex_pkg::ST_DOT;
					end else begin
						emit = 1'b1;
						ok   = nlex_pkg::ends_number(rd.cls);
						tc   = neg_q ? nlex_pkg::TC_NEG_INT : nlex_pkg::TC_POS_INT;
					end
				end
				nlex_pkg::ST_FRAC: begin
					if (rd.cls == nlex_pkg::CC_DIGIT) begin
						count_en = 1'b1;
					end else begin
						emit = 1'b1;
						ok   = nlex_pkg::ends_number(rd.cls);
						tc   = neg_q ? nlex_pkg::TC_NEG_DEC : nlex_pkg::TC_POS_DEC;
					end
				end
				nlex_pkg::ST_T1: begin
					count_en = (rd.cls == nlex_pkg::CC_R);
					emit     = !count_en;
					state_d  = nlex_pkg::ST_T2;
				end
				nlex_pkg::ST_T2: begin
					count_en = (rd.cls == nlex_pkg::CC_U);
					emit     = !count_en;
					state_d  = nlex_pkg::ST_T3;
				end
				nlex_pkg::ST_T3: begin
					count_en = (rd.cls == nlex_pkg::CC_E);
					emit     = !count_en;
					state_d  = nlex_pkg::ST_TRUE;
				end
				nlex_pkg::ST_F1: begin
					count_en = (rd.cls == nlex_pkg::CC_A);
					emit     = !count_en;
					state_d  = nlex_pkg::ST_F2;
				end
				nlex_pkg::ST_F2: begin
					count_en = (rd.cls == nlex_pkg::CC_L);
					emit     = !count_en;
					state_d  = nlex_pkg::ST_F3;
				end
				nlex_pkg::ST_F3: begin
					count_en = (rd.cls == nlex_pkg::CC_S);
					emit     = !count_en;
					state_d  = nlex_pkg::ST_F4;
				end
				nlex_pkg::ST_F4: begin
					count_en = (rd.cls == nlex_pkg::CC_E);
					emit     = !count_en;
					state_d  = nlex_pkg::ST_FALSE;
				end
				nlex_pkg::ST_TRUE: begin
					emit = 1'b1;
					ok   = (rd.cls == nlex_pkg::CC_SEMI);
					tc   = nlex_pkg::TC_TRUE;
				end
				nlex_pkg::ST_FALSE: begin
					emit = 1'b1;
					ok   = (rd.cls == nlex_pkg::CC_SEMI);
					tc   = nlex_pkg::TC_FALSE;
				end
				default: begin
					emit = 1'b1;
				end
			endcase
			// A decision leaves the automaton where it stands.
			if (emit) begin
				state_d = state_q;
			end
		end
	end

	// Result word; a rejection carries zeros in every other field.
	always_comb begin
		result_d = '0;
		result_d[0] = ok;
		if (ok) begin
			result_d[3:1]  = tc;
			result_d[11:4] = cnt_q[7:0];
			result_d[12]   = sat_q;
		end
	end

	// Automaton registers and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= nlex_pkg::ST_START;
			neg_q      <= 1'b0;
			cnt_q      <= '0;
			decided_q  <= 1'b0;
			sat_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop && emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (pop) begin
				if (is_eos) begin
					state_q   <= nlex_pkg::ST_START;
					neg_q     <= 1'b0;
					cnt_q     <= '0;
					decided_q <= 1'b0;
					sat_q     <= 1'b0;
				end else begin
					state_q <= state_d;
					if (set_neg) begin
						neg_q <= 1'b1;
					end
					if (emit) begin
						decided_q <= 1'b1;
					end
					if (count_en) begin
						if (cnt_q >= MAX_CNT) begin
							sat_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			m_tdata_q <= result_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### src/number_literal_lexer_unit.sv
// Top level of the number literal lexer: front end, word queue and back end.
// An accepted word is written into the queue; the back end pops it and registers m_tvalid and the result on a decision.
// Throughput: one word per cycle while the result register is free or being drained.
// A four-word queue lets the input side keep going while the result side stalls.
// Reset is asynchronous and active low; it empties the queue and the result register
// and returns the automaton to its start state.
module number_literal_lexer_unit #(
	parameter int unsigned MAX_LEN = nlex_pkg::MAX_LEN_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [7:0] ch
	input  logic [nlex_pkg::S_TDATA_W-1:0]      s_tdata,
	// [0] kind
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [0] accepted, [3:1] token_class, [11:4] lexeme_length, [12] length_overflow
	output logic [nlex_pkg::M_TDATA_W-1:0]      m_tdata
);

	nlex_pkg::qword_t q_wr;
	nlex_pkg::qword_t q_rd;
	logic             q_full;
	logic             q_pop;

	// Classification of incoming words.
	nlex_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_wr     (q_wr)
	);

	// Decoupling queue.
	nlex_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.full   (q_full),
		.rd     (q_rd),
		.pop    (q_pop)
	);

	// Automaton and result register.
	nlex_back #(
		.MAX_LEN (MAX_LEN)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd       (q_rd),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

### src/nlex_checker.sv
// Port-level checker of the lexer and its binding to the top level.
`include "assert_macros.svh"

module nlex_checker #(
	parameter int unsigned MAX_LEN = nlex_pkg::MAX_LEN_DEFAULT
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic [nlex_pkg::S_TDATA_W-1:0]      s_tdata,
	input logic                                s_tuser,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [nlex_pkg::M_TDATA_W-1:0]      m_tdata
);

	localparam logic [7:0] MAX_LEN_LOW = 8'(MAX_LEN);

	logic                   in_stall;
	logic [8:0]             in_word;
	logic                   out_stall;
	nlex_pkg::token_class_t res_cls;
	logic [7:0]             res_len;
	logic                   res_rej;
	logic                   res_kw;
	logic                   res_ovf;
	logic [7:0]             kw_len;

	// Views of the stream ports used by the checks below.
	assign in_stall  = s_tvalid && !s_tready;
	assign in_word   = {s_tuser, s_tdata};
	assign out_stall = m_tvalid && !m_tready;
	assign res_cls   = m_tdata[3:1];
	assign res_len   = m_tdata[11:4];
	assign res_rej   = m_tvalid && !m_tdata[0];
	assign res_kw    = m_tvalid && m_tdata[0] &&
		((res_cls == nlex_pkg::TC_TRUE) || (res_cls == nlex_pkg::TC_FALSE));
	assign res_ovf   = m_tvalid && m_tdata[12];
	assign kw_len    = (res_cls == nlex_pkg::TC_TRUE) ? 8'd4 : 8'd5;

	// A stalled input word stays offered and unchanged.
	`NLEX_ASSERT_NXT(a_in_hold, clk, arst_n, in_stall, s_tvalid && $stable(in_word), "input not held")

	// A stalled result word keeps its value.
	`NLEX_ASSERT_NXT(a_hold, clk, arst_n, out_stall, m_tvalid && $stable(m_tdata), "output not held")

	// A rejection carries no class, length or overflow.
	`NLEX_ASSERT_IMP(a_reject_zero, clk, arst_n, res_rej, m_tdata[12:1] == '0, "reject with fields")

	// Keywords always have their fixed length.
	`NLEX_ASSERT_IMP(a_kw_len, clk, arst_n, res_kw, res_len == kw_len, "keyword length wrong")

	// An overflowing lexeme reports the saturated length.
	`NLEX_ASSERT_IMP(a_ovf_len, clk, arst_n, res_ovf, res_len == MAX_LEN_LOW, "overflow length wrong")

endmodule

bind number_literal_lexer_unit nlex_checker #(
	.MAX_LEN (MAX_LEN)
) u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
